// File: hw/rtl/dmmgs_pkg.sv
`default_nettype none

package dmmgs_pkg;

   localparam int ACTION_W           = 2;
   localparam int REQ_DEPTH_W        = 15;
   localparam int PIXEL_W            = 24;
   localparam int GREY_W             = 8;
   localparam int DEPTH_BITS_DEFAULT = 15;

   typedef enum logic [ACTION_W-1:0] {
      ACT_MEASURE = 2'd0,
      ACT_CONVERT = 2'd1,
      ACT_COLOR   = 2'd2
   } action_type;

   typedef enum logic {
      TOP_IDLE,
      TOP_WAIT
   } top_state_type;

   typedef enum logic [2:0] {
      DIV_IDLE,
      DIV_SCALE,
      DIV_CLAMP,
      DIV_STEP,
      DIV_DONE
   } div_state_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

// File: hw/rtl/dmmgs_if.sv
`default_nettype none

interface dmmgs_req_if;
   logic                               valid;
   logic                               ready;
   logic [dmmgs_pkg::ACTION_W-1:0]     action;
   logic [dmmgs_pkg::REQ_DEPTH_W-1:0]  depth;
   logic [dmmgs_pkg::PIXEL_W-1:0]      color_pixel;
   logic                               frame_start;

   modport source (output valid, action, depth, color_pixel, frame_start, input ready);
   modport sink   (input valid, action, depth, color_pixel, frame_start, output ready);
endinterface

interface dmmgs_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [dmmgs_pkg::PIXEL_W-1:0]  rgb;

   modport source (output valid, rgb, input ready);
   modport sink   (input valid, rgb, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dmmgs_div.sv
`default_nettype none

module dmmgs_div #(
   parameter int DEPTH_BITS = dmmgs_pkg::DEPTH_BITS_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire dmmgs_pkg::div_ctrl_type     ctrl,
   input  wire  [DEPTH_BITS-1:0]            diff,
   input  wire  [DEPTH_BITS-1:0]            den,
   output dmmgs_pkg::div_stat_type          stat,
   output logic [dmmgs_pkg::GREY_W-1:0]     quotient
);

   localparam int GW = dmmgs_pkg::GREY_W;
   localparam int RW = DEPTH_BITS + GW;
   localparam int CW = $clog2(GW);

   dmmgs_pkg::div_state_type state_ff, state_in;
   logic [DEPTH_BITS-1:0] diff_ff, diff_in;
   logic [DEPTH_BITS-1:0] den_ff, den_in;
   logic [RW-1:0]         rem_ff, rem_in;
   logic [RW-1:0]         dsh_ff, dsh_in;
   logic [GW-1:0]         quo_ff, quo_in;
   logic [CW-1:0]         cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dmmgs_pkg::DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      diff_ff <= diff_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dmmgs_pkg::DIV_IDLE:  if (ctrl.start) state_in = dmmgs_pkg::DIV_SCALE;
         dmmgs_pkg::DIV_SCALE: state_in = dmmgs_pkg::DIV_CLAMP;
         dmmgs_pkg::DIV_CLAMP: begin
            if (rem_ff >= {den_ff, {GW{1'b0}}}) state_in = dmmgs_pkg::DIV_DONE;
            else                                state_in = dmmgs_pkg::DIV_STEP;
         end
         dmmgs_pkg::DIV_STEP:  if (cnt_ff == '0) state_in = dmmgs_pkg::DIV_DONE;
         dmmgs_pkg::DIV_DONE:  state_in = dmmgs_pkg::DIV_IDLE;
         default:              state_in = dmmgs_pkg::DIV_IDLE;
      endcase
   end

   always_comb begin
      diff_in = diff_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      case (state_ff)
         dmmgs_pkg::DIV_IDLE: begin
            if (ctrl.start) begin
               diff_in = diff;
               den_in  = den;
            end
         end
         // scale by 255 as x*256 - x
         dmmgs_pkg::DIV_SCALE: begin
            rem_in = {diff_ff, {GW{1'b0}}} - {{GW{1'b0}}, diff_ff};
         end
         // saturate when the quotient would not fit a byte
         dmmgs_pkg::DIV_CLAMP: begin
            if (rem_ff >= {den_ff, {GW{1'b0}}}) begin
               quo_in = '1;
            end else begin
               quo_in = '0;
               dsh_in = {1'b0, den_ff, {(GW-1){1'b0}}};
               cnt_in = CW'(GW - 1);
            end
         end
         dmmgs_pkg::DIV_STEP: begin
            if (rem_ff >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff;
               quo_in = {quo_ff[GW-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[GW-2:0], 1'b0};
            end
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      stat.busy = (state_ff != dmmgs_pkg::DIV_IDLE);
      stat.done = (state_ff == dmmgs_pkg::DIV_DONE);
      quotient  = quo_ff;
   end

endmodule

`default_nettype wire

// File: hw/rtl/depth_min_max_grey_stretch_unit.sv
// Depth min/max grey stretch with color byte reorder.
// req channel carries action, depth, color_pixel and frame_start; rsp carries rgb.
// A measure transfer updates the running nonzero minimum and the maximum
// (frame_start clears them first) and gives no result. A convert transfer gives
// the grey byte (v - min) * 255 / range, clamped to 0..255, in all three bytes.
// A color transfer gives the pixel with its byte order reversed.
// Measure, color and convert of a sample below the minimum or while the maximum
// is below the minimum skip the divider; a result is in the rsp register the
// cycle after the transfer, and such transfers can follow every cycle while
// the receiver keeps up. Other converts run through a serial divider that
// retires one quotient bit per cycle: a scale step, a saturation test, eight
// quotient steps and a hand-over step; a saturated quotient skips the quotient
// steps and goes straight to the hand-over.
// req.ready is low while the divider runs and while a result sits in the rsp
// register that the receiver does not take in the same cycle; a stalled rsp
// holds its value. Reset sets the minimum to all ones, the maximum to zero,
// and empties the rsp register.
`default_nettype none

module depth_min_max_grey_stretch_unit #(
   parameter int DEPTH_BITS = dmmgs_pkg::DEPTH_BITS_DEFAULT
) (
   input wire          clock,
   input wire          reset,
   dmmgs_req_if.sink   req,
   dmmgs_rsp_if.source rsp
);

   localparam int GW = dmmgs_pkg::GREY_W;
   localparam int PW = dmmgs_pkg::PIXEL_W;

   dmmgs_pkg::top_state_type state_ff, state_in;
   logic [DEPTH_BITS-1:0] min_ff, min_in;
   logic [DEPTH_BITS-1:0] max_ff, max_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]         rsp_rgb_ff, rsp_rgb_in;

   logic [DEPTH_BITS-1:0] sample;
   logic [DEPTH_BITS-1:0] base_min;
   logic [DEPTH_BITS-1:0] base_max;
   logic [DEPTH_BITS-1:0] diff;
   logic [DEPTH_BITS-1:0] den;
   logic                  grey_zero;
   logic                  accept;
   logic                  out_free;
   logic [GW-1:0]         quotient;

   dmmgs_pkg::div_ctrl_type div_ctrl;
   dmmgs_pkg::div_stat_type div_stat;

   dmmgs_div #(
      .DEPTH_BITS (DEPTH_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .diff     (diff),
      .den      (den),
      .stat     (div_stat),
      .quotient (quotient)
   );

   assign sample    = req.depth[DEPTH_BITS-1:0];
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign grey_zero = (max_ff < min_ff) || (sample < min_ff);
   assign diff      = sample - min_ff;
   assign den       = (max_ff == min_ff) ? DEPTH_BITS'(1) : (max_ff - min_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dmmgs_pkg::TOP_IDLE;
         min_ff       <= '1;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_rgb_ff <= rsp_rgb_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dmmgs_pkg::TOP_IDLE: begin
            if (accept && req.action == dmmgs_pkg::ACT_CONVERT && !grey_zero) begin
               state_in = dmmgs_pkg::TOP_WAIT;
            end
         end
         dmmgs_pkg::TOP_WAIT: if (div_stat.done) state_in = dmmgs_pkg::TOP_IDLE;
         default:             state_in = dmmgs_pkg::TOP_IDLE;
      endcase
   end

   always_comb begin
      req.ready = (state_ff == dmmgs_pkg::TOP_IDLE) && out_free;
      div_ctrl.start = accept && (req.action == dmmgs_pkg::ACT_CONVERT) && !grey_zero;
      rsp.valid = rsp_valid_ff;
      rsp.rgb   = rsp_rgb_ff;
   end

   always_comb begin
      base_min = req.frame_start ? '1 : min_ff;
      base_max = req.frame_start ? '0 : max_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      if (accept && req.action == dmmgs_pkg::ACT_MEASURE) begin
         min_in = (sample != '0 && sample < base_min) ? sample : base_min;
         max_in = (sample > base_max) ? sample : base_max;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_rgb_in   = rsp_rgb_ff;
      if (div_stat.done) begin
         rsp_valid_in = 1'b1;
         rsp_rgb_in   = {3{quotient}};
      end else if (accept) begin
         case (req.action)
            dmmgs_pkg::ACT_CONVERT: begin
               if (grey_zero) begin
                  rsp_valid_in = 1'b1;
                  rsp_rgb_in   = '0;
               end
            end
            dmmgs_pkg::ACT_COLOR: begin
               rsp_valid_in = 1'b1;
               rsp_rgb_in   = {req.color_pixel[7:0], req.color_pixel[15:8],
                               req.color_pixel[23:16]};
            end
            default: begin
            end
         endcase
      end
   end

   a_wait_tracks_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dmmgs_pkg::TOP_WAIT) == div_stat.busy)
      else $error("sequencer state and divider activity disagree");

   a_no_take_while_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> !req.ready)
      else $error("request taken while divider runs");

   a_done_finds_room: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> !rsp_valid_ff)
      else $error("divider result would overwrite a pending response");

   a_min_nonzero: assert property (@(posedge clock) disable iff (reset)
      min_ff != '0)
      else $error("minimum of nonzero samples became zero");

endmodule

`default_nettype wire

// File: tb/dmmgs_grey_checker.sv
`timescale 1ns / 100ps

module dmmgs_grey_checker (
   input wire   clock,
   input wire   reset,
   dmmgs_req_if req,
   dmmgs_rsp_if rsp,
   output int   fail_count,
   output int   pending_count
);

   localparam int DW = dmmgs_pkg::REQ_DEPTH_W;
   localparam int PXW = dmmgs_pkg::PIXEL_W;
   localparam int GRW = dmmgs_pkg::GREY_W;
   localparam logic [DW-1:0] DEPTH_FULL = {DW{1'b1}};
   localparam int unsigned GREY_FULL = 255;

   logic [DW-1:0]  depth_min;
   logic [DW-1:0]  depth_max;
   logic [PXW-1:0] rgb_expected[$];

   function automatic logic [GRW-1:0] grey_stretch_of(input logic [DW-1:0] v);
      int unsigned span;
      int unsigned offset;
      int unsigned quotient;
      if (depth_max < depth_min || v < depth_min) begin
         return '0;
      end
      span     = (depth_max == depth_min) ? 1 : int'(depth_max) - int'(depth_min);
      offset   = int'(v) - int'(depth_min);
      quotient = offset * GREY_FULL / span;
      if (quotient > GREY_FULL) begin
         quotient = GREY_FULL;
      end
      return quotient[GRW-1:0];
   endfunction

   always @(posedge clock) begin
      logic [PXW-1:0] want;
      if (reset) begin
         depth_min = DEPTH_FULL;
         depth_max = '0;
         rgb_expected.delete();
      end else begin
         // retire the older result before taking in a new transfer
         if (rsp.valid && rsp.ready) begin
            if (rgb_expected.size() == 0) begin
               $error("rgb: expected no transfer, actual %06h", rsp.rgb);
               fail_count++;
            end else begin
               want = rgb_expected.pop_front();
               if (rsp.rgb !== want) begin
                  $error("rgb: expected %06h, actual %06h", want, rsp.rgb);
                  fail_count++;
               end
            end
         end
         if (req.valid && req.ready) begin
            case (req.action)
               dmmgs_pkg::ACT_MEASURE: begin
                  if (req.frame_start) begin
                     depth_min = DEPTH_FULL;
                     depth_max = '0;
                  end
                  if (req.depth != '0 && req.depth < depth_min) begin
                     depth_min = req.depth;
                  end
                  if (req.depth > depth_max) begin
                     depth_max = req.depth;
                  end
               end
               dmmgs_pkg::ACT_CONVERT: begin
                  rgb_expected.push_back({3{grey_stretch_of(req.depth)}});
               end
               dmmgs_pkg::ACT_COLOR: begin
                  rgb_expected.push_back({req.color_pixel[7:0], req.color_pixel[15:8],
                                          req.color_pixel[23:16]});
               end
               default: begin
               end
            endcase
         end
      end
      pending_count = rgb_expected.size();
   end

endmodule

// File: tb/tb_depth_min_max_grey_stretch_unit.sv
`timescale 1ns / 100ps

module tb_depth_min_max_grey_stretch_unit;

   localparam int AW  = dmmgs_pkg::ACTION_W;
   localparam int DW  = dmmgs_pkg::REQ_DEPTH_W;
   localparam int PXW = dmmgs_pkg::PIXEL_W;
   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 8;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_ITEMS  = 145;
   localparam int MAX_GAP      = 40;
   localparam logic [AW-1:0] ACT_RESERVED = 2'd3;
   localparam logic [DW-1:0] DEPTH_FULL   = {DW{1'b1}};

   logic clock     = 1'b0;
   logic reset     = 1'b1;
   logic hold_rsp  = 1'b0;
   logic hold_done = 1'b0;
   int   sender_idle_pct = 0;
   int   rsp_stall_pct   = 0;
   int   items_sent      = 0;
   int   fail_count;
   int   pending_count;

   dmmgs_req_if req_if();
   dmmgs_rsp_if rsp_if();

   depth_min_max_grey_stretch_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   dmmgs_grey_checker grey_checker (
      .clock         (clock),
      .reset         (reset),
      .req           (req_if),
      .rsp           (rsp_if),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #HALF_PERIOD clock = ~clock;

   initial begin
      #(20_000_000);
      $display("FAIL");
      $finish;
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp && !hold_done) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   function automatic logic [DW-1:0] rand_depth();
      case ($urandom_range(7))
         0:       return '0;
         1:       return DEPTH_FULL;
         2:       return DW'($urandom_range(255, 1));
         default: return DW'($urandom_range(32767));
      endcase
   endfunction

   function automatic logic [PXW-1:0] rand_pixel();
      return PXW'($urandom);
   endfunction

   function automatic logic [AW-1:0] rand_action();
      case ($urandom_range(2))
         0:       return dmmgs_pkg::ACT_MEASURE;
         1:       return dmmgs_pkg::ACT_CONVERT;
         default: return dmmgs_pkg::ACT_COLOR;
      endcase
   endfunction

   task automatic send_item(input logic [AW-1:0] act, input logic [DW-1:0] d,
                            input logic [PXW-1:0] px, input logic fs);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) begin
         gap++;
      end
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.action      <= act;
      req_if.depth       <= d;
      req_if.color_pixel <= px;
      req_if.frame_start <= fs;
      do begin
         @(posedge clock);
      end while (!req_if.ready);
      if (act != ACT_RESERVED) begin
         items_sent++;
      end
   endtask

   task automatic run_random(input int goal);
      int stop;
      int n_meas;
      logic [DW-1:0] frame[$];
      logic [DW-1:0] d;
      stop = items_sent + goal;
      while (items_sent < stop) begin
         case ($urandom_range(9))
            0: begin
               send_item(ACT_RESERVED, rand_depth(), rand_pixel(), 1'($urandom));
               send_item(rand_action(), rand_depth(), rand_pixel(), 1'($urandom));
            end
            1: begin
               send_item(dmmgs_pkg::ACT_COLOR, rand_depth(), rand_pixel(), 1'($urandom));
            end
            default: begin
               // measure pass, then a convert pass over the same frame, mixed with colors and converts of random depths
               n_meas = $urandom_range(8, 1);
               frame.delete();
               for (int i = 0; i < n_meas; i++) begin
                  d = rand_depth();
                  frame.push_back(d);
                  send_item(dmmgs_pkg::ACT_MEASURE, d, rand_pixel(),
                            (i == 0 && $urandom_range(7) != 0) || $urandom_range(15) == 0);
               end
               for (int i = 0; i < n_meas + 2; i++) begin
                  if ($urandom_range(4) == 0) begin
                     send_item(dmmgs_pkg::ACT_COLOR, rand_depth(), rand_pixel(),
                               1'($urandom));
                  end else if ($urandom_range(3) == 0) begin
                     send_item(dmmgs_pkg::ACT_CONVERT, rand_depth(), rand_pixel(),
                               1'($urandom));
                  end else begin
                     d = frame[$urandom_range(n_meas - 1)] + DW'($urandom_range(2))
                         - DW'(1);
                     send_item(dmmgs_pkg::ACT_CONVERT, d, rand_pixel(), 1'($urandom));
                  end
               end
            end
         endcase
      end
   endtask

   initial begin
      req_if.valid       = 1'b0;
      req_if.action      = dmmgs_pkg::ACT_MEASURE;
      req_if.depth       = '0;
      req_if.color_pixel = '0;
      req_if.frame_start = 1'b0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // nothing measured yet: every convert is zero
      send_item(dmmgs_pkg::ACT_CONVERT, '0, '0, 1'b0);
      send_item(dmmgs_pkg::ACT_CONVERT, DEPTH_FULL, '1, 1'b0);
      send_item(dmmgs_pkg::ACT_COLOR, '0, 24'h000000, 1'b0);
      send_item(dmmgs_pkg::ACT_COLOR, DEPTH_FULL, 24'hFFFFFF, 1'b1);
      send_item(dmmgs_pkg::ACT_COLOR, '0, 24'h123456, 1'b0);
      send_item(ACT_RESERVED, 15'd500, 24'hABCDEF, 1'b1);
      send_item(dmmgs_pkg::ACT_CONVERT, 15'd500, '0, 1'b0);
      // frame of zeros only
      send_item(dmmgs_pkg::ACT_MEASURE, '0, '0, 1'b1);
      send_item(dmmgs_pkg::ACT_CONVERT, '0, '0, 1'b0);
      send_item(dmmgs_pkg::ACT_CONVERT, DEPTH_FULL, '0, 1'b0);
      // flat frame
      send_item(dmmgs_pkg::ACT_MEASURE, 15'd100, '0, 1'b1);
      send_item(dmmgs_pkg::ACT_CONVERT, 15'd99, '0, 1'b0);
      send_item(dmmgs_pkg::ACT_CONVERT, 15'd100, '0, 1'b0);
      send_item(dmmgs_pkg::ACT_CONVERT, 15'd101, '0, 1'b0);
      // full range
      send_item(dmmgs_pkg::ACT_MEASURE, DEPTH_FULL, '0, 1'b0);
      send_item(dmmgs_pkg::ACT_MEASURE, 15'd1, '0, 1'b0);
      send_item(dmmgs_pkg::ACT_CONVERT, '0, '0, 1'b0);
      send_item(dmmgs_pkg::ACT_CONVERT, 15'd1, '0, 1'b0);
      send_item(dmmgs_pkg::ACT_CONVERT, 15'd16384, '0, 1'b0);
      send_item(dmmgs_pkg::ACT_CONVERT, DEPTH_FULL, '0, 1'b1);
      // mid range with clamp above the maximum
      send_item(dmmgs_pkg::ACT_MEASURE, 15'd300, '0, 1'b1);
      send_item(dmmgs_pkg::ACT_MEASURE, 15'd700, '0, 1'b0);
      send_item(dmmgs_pkg::ACT_CONVERT, 15'd500, '0, 1'b0);
      send_item(dmmgs_pkg::ACT_CONVERT, 15'd800, '0, 1'b0);

      hold_rsp = 1'b1;
      run_random(PHASE_ITEMS);

      sender_idle_pct = 67;
      run_random(PHASE_ITEMS);

      sender_idle_pct = 0;
      rsp_stall_pct   = 67;
      run_random(PHASE_ITEMS);

      sender_idle_pct = 20;
      rsp_stall_pct   = 20;
      run_random(PHASE_ITEMS);

      @(negedge clock);
      req_if.valid <= 1'b0;
      rsp_stall_pct = 0;
      wait (pending_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
